// ===== design/lrwg_pkg.sv =====
// Package for the late-reverb Wiener bin gain block.
// Holds sizes, fixed-point constants and configuration register indexes.
// No dependencies; used by the channel interfaces and the top level.
package lrwg_pkg;

    // Frame geometry and history depth.
    localparam int unsigned NUM_BINS    = 513;
    localparam int unsigned HIST_FRAMES = 10;
    localparam int unsigned HIST_DEPTH  = NUM_BINS * HIST_FRAMES;
    localparam int unsigned HIST_AW     = $clog2(HIST_DEPTH);
    localparam int unsigned GAIN_AW     = $clog2(NUM_BINS);
    localparam int unsigned FRAME_W     = $clog2(HIST_FRAMES);

    // Field widths.
    localparam int unsigned SAMPLE_W = 24;
    localparam int unsigned INDEX_W  = 10;
    localparam int unsigned GAIN_W   = 17;
    localparam int unsigned POWER_W  = 48;
    localparam int unsigned SCALE_W  = 20;
    localparam int unsigned CFG_AW   = 3;
    localparam int unsigned CFG_DW   = 20;

    // Unity gain in Q1.16.
    localparam logic [GAIN_W-1:0] ONE_Q16 = 17'd65536;

    // Configuration register indexes.
    typedef enum logic [CFG_AW-1:0] {
        REG_AMOUNT      = 3'd0,
        REG_LATE_SCALE  = 3'd1,
        REG_FLOOR_GAIN  = 3'd2,
        REG_VOICE_FLOOR = 3'd3,
        REG_SMOOTH      = 3'd4,
        REG_VOICE_MODE  = 3'd5,
        REG_SPEECH_LOW  = 3'd6,
        REG_SPEECH_HIGH = 3'd7
    } t_reg_idx;

endpackage

// ===== design/lrwg_in_if.sv =====
// Input channel: one complex STFT bin word with its index and last-bin flag.
// Depends on lrwg_pkg for field widths.
interface lrwg_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [lrwg_pkg::SAMPLE_W-1:0] bin_real;
    logic signed [lrwg_pkg::SAMPLE_W-1:0] bin_imag;
    logic        [lrwg_pkg::INDEX_W-1:0]  bin_index;
    logic                                 last_bin;

    modport source (output valid, bin_real, bin_imag, bin_index, last_bin, input ready);
    modport sink   (input valid, bin_real, bin_imag, bin_index, last_bin, output ready);
endinterface

// ===== design/lrwg_out_if.sv =====
// Output channel: one gained bin word with the applied gain and frame-end flag.
// Depends on lrwg_pkg for field widths.
interface lrwg_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [lrwg_pkg::SAMPLE_W-1:0] out_real;
    logic signed [lrwg_pkg::SAMPLE_W-1:0] out_imag;
    logic        [lrwg_pkg::GAIN_W-1:0]   applied_gain;
    logic                                 frame_end;

    modport source (output valid, out_real, out_imag, applied_gain, frame_end, input ready);
    modport sink   (input valid, out_real, out_imag, applied_gain, frame_end, output ready);
endinterface

// ===== design/late_reverb_wiener_bin_gain.sv =====
// Top level of the late-reverb Wiener bin gain block.
// Depends on lrwg_pkg, lrwg_in_if and lrwg_out_if.
//
//  Channel     | Direction | Handshake     | Word
//  i_bin       | in        | valid/ready   | bin_real, bin_imag, bin_index, last_bin
//  o_bin       | out       | valid/ready   | out_real, out_imag, applied_gain, frame_end
//  i_cfg_*     | in        | write enable  | register index, write data
//
// One word per cycle is accepted unless a stall, the clearing pass or the interlock holds it;
// each word passes a 43-stage pipeline (a 16-stage restoring divider and a 17-stage square root).
// After reset a clearing pass writes the history and gain memories;
// no word is accepted during that pass.
// A word for a bin that is still in flight up to the memory write-back waits (interlock).
// The whole pipeline holds while the output register is full and not taken.
module late_reverb_wiener_bin_gain (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lrwg_pkg::CFG_AW-1:0]     i_cfg_index,
    input  logic [lrwg_pkg::CFG_DW-1:0]     i_cfg_wdata,
    lrwg_in_if.sink                         i_bin,
    lrwg_out_if.source                      o_bin
);

    // Pipeline stage positions.
    localparam int NST   = 43;
    localparam int DIV0  = 4;
    localparam int RAT   = 20;
    localparam int WST   = 21;
    localparam int SQ0   = 22;
    localparam int SMO   = 39;
    localparam int GST   = 40;
    localparam int PRD   = 41;
    localparam int LST   = 42;

    typedef struct packed {
        logic signed [23:0] re;
        logic signed [23:0] im;
        logic [9:0]         k;
        logic               inr;
        logic               last;
        logic [lrwg_pkg::HIST_AW-1:0] addr;
        logic [16:0]        fl;
        logic [16:0]        gold;
        logic [46:0]        sqr;
        logic [46:0]        sqi;
        logic [47:0]        pw;
        logic [43:0]        plo;
        logic [43:0]        phi;
        logic [47:0]        pp;
        logic [67:0]        rem;
        logic               sat;
        logic [15:0]        q;
        logic [33:0]        ar;
        logic [33:0]        f2;
        logic [34:0]        wr;
        logic [16:0]        rt;
        logic [33:0]        m1;
        logic [33:0]        m2;
        logic [16:0]        g;
        logic signed [41:0] pr;
        logic signed [41:0] pi;
        logic signed [23:0] ore;
        logic signed [23:0] oim;
    } t_stage;

    // Configuration registers.
    logic [16:0] r_amount, r_floor, r_vfloor, r_alpha;
    logic [19:0] r_scale;
    logic        r_voice;
    logic [9:0]  r_low, r_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amount <= 17'd65536;
            r_scale  <= 20'd16384;
            r_floor  <= 17'd6554;
            r_vfloor <= 17'd23170;
            r_alpha  <= 17'd45875;
            r_voice  <= 1'b0;
            r_low    <= 10'd4;
            r_high   <= 10'd85;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lrwg_pkg::REG_AMOUNT:      r_amount <= i_cfg_wdata[16:0];
                lrwg_pkg::REG_LATE_SCALE:  r_scale  <= i_cfg_wdata;
                lrwg_pkg::REG_FLOOR_GAIN:  r_floor  <= i_cfg_wdata[16:0];
                lrwg_pkg::REG_VOICE_FLOOR: r_vfloor <= i_cfg_wdata[16:0];
                lrwg_pkg::REG_SMOOTH:      r_alpha  <= i_cfg_wdata[16:0];
                lrwg_pkg::REG_VOICE_MODE:  r_voice  <= i_cfg_wdata[0];
                lrwg_pkg::REG_SPEECH_LOW:  r_low    <= i_cfg_wdata[9:0];
                lrwg_pkg::REG_SPEECH_HIGH: r_high   <= i_cfg_wdata[9:0];
                default: ;
            endcase
        end
    end

    // Register values above unity saturate to unity.
    logic [16:0] amt_s, alpha_s;
    assign amt_s   = (r_amount > lrwg_pkg::ONE_Q16) ? lrwg_pkg::ONE_Q16 : r_amount;
    assign alpha_s = (r_alpha > lrwg_pkg::ONE_Q16) ? lrwg_pkg::ONE_Q16 : r_alpha;

    // Pipeline state.
    t_stage r_st [NST];
    t_stage n_st [NST];
    logic   r_v  [NST];
    logic   en, accept, hazard, in_range;

    logic [lrwg_pkg::FRAME_W-1:0] r_frame;
    logic                         r_clr_busy;
    logic [lrwg_pkg::HIST_AW-1:0] r_clr_cnt;
    logic [lrwg_pkg::HIST_AW-1:0] in_addr;

    // Memories and their registered read data.
    logic [47:0] hist_mem [lrwg_pkg::HIST_DEPTH];
    logic [16:0] gain_mem [lrwg_pkg::NUM_BINS];
    logic [47:0] r_hist_rd;
    logic [16:0] r_gain_rd;

    assign en       = !r_v[LST] || o_bin.ready;
    assign in_range = 32'(i_bin.bin_index) < lrwg_pkg::NUM_BINS;
    assign in_addr  = lrwg_pkg::HIST_AW'(32'(r_frame) * lrwg_pkg::NUM_BINS)
                      + lrwg_pkg::HIST_AW'(i_bin.bin_index);

    // Interlock: a bin still in flight before its write-back blocks a new word of that bin.
    always_comb begin
        hazard = 1'b0;
        for (int s = 0; s < GST; s++) begin
            if (r_v[s] && r_st[s].inr && r_st[s].k == i_bin.bin_index) begin
                hazard = 1'b1;
            end
        end
    end

    assign i_bin.ready = en && !r_clr_busy && !hazard;
    assign accept      = i_bin.valid && i_bin.ready;

    // Next-stage logic for every pipeline stage.
    always_comb begin
        logic        band;
        logic [16:0] fsel;
        logic [67:0] dtrial;
        logic [34:0] strial;
        logic [16:0] ratio;
        logic [32:0] wsub;
        logic [33:0] gsum;
        int          si;

        // Entry stage: capture the word and square both parts.
        n_st[0]      = r_st[0];
        n_st[0].re   = i_bin.bin_real;
        n_st[0].im   = i_bin.bin_imag;
        n_st[0].k    = i_bin.bin_index;
        n_st[0].inr  = in_range;
        n_st[0].last = i_bin.last_bin;
        n_st[0].addr = in_addr;
        band = r_voice && (i_bin.bin_index >= r_low) && (i_bin.bin_index <= r_high);
        fsel = band ? r_vfloor : r_floor;
        n_st[0].fl   = (fsel > lrwg_pkg::ONE_Q16) ? lrwg_pkg::ONE_Q16 : fsel;
        n_st[0].sqr  = 47'(i_bin.bin_real * i_bin.bin_real);
        n_st[0].sqi  = 47'(i_bin.bin_imag * i_bin.bin_imag);

        for (int s = 1; s < NST; s++) begin
            n_st[s] = r_st[s-1];
        end

        // Bin power and the scaled history partial products.
        n_st[1].pw   = {1'b0, r_st[0].sqr} + {1'b0, r_st[0].sqi};
        n_st[1].gold = r_gain_rd;
        n_st[1].plo  = r_scale * r_hist_rd[23:0];
        n_st[1].phi  = r_scale * r_hist_rd[47:24];

        // Scaled history and the divisor floored at one.
        n_st[2].rem = 68'(r_st[1].plo) + (68'(r_st[1].phi) << 24);
        n_st[2].pp  = (r_st[1].pw == 48'd0) ? 48'd1 : r_st[1].pw;

        // Ratio clamps to one when the estimate reaches the bin power.
        n_st[3].sat = r_st[2].rem >= (68'(r_st[2].pp) << 16);
        n_st[3].q   = '0;

        // Restoring divider, one quotient bit per stage.
        for (int j = 0; j < 16; j++) begin
            si = 15 - j;
            dtrial = 68'(r_st[DIV0+j-1].pp) << si;
            if (!r_st[DIV0+j-1].sat && r_st[DIV0+j-1].rem >= dtrial) begin
                n_st[DIV0+j].rem    = r_st[DIV0+j-1].rem - dtrial;
                n_st[DIV0+j].q[si]  = 1'b1;
            end
        end

        // Strength times ratio, and the squared floor.
        ratio = r_st[RAT-1].sat ? lrwg_pkg::ONE_Q16 : {1'b0, r_st[RAT-1].q};
        n_st[RAT].ar = amt_s * ratio;
        n_st[RAT].f2 = r_st[RAT-1].fl * r_st[RAT-1].fl;

        // Power gain with floor.
        wsub = 33'h1_0000_0000 - r_st[WST-1].ar[32:0];
        n_st[WST].wr = (34'(wsub) < r_st[WST-1].f2) ? 35'(r_st[WST-1].f2) : 35'(wsub);
        n_st[WST].rt = '0;

        // Square root, one root bit per stage.
        for (int j = 0; j < 17; j++) begin
            si = 16 - j;
            strial = (35'(r_st[SQ0+j-1].rt) << (si + 1)) + (35'd1 << (2 * si));
            if (r_st[SQ0+j-1].wr >= strial) begin
                n_st[SQ0+j].wr     = r_st[SQ0+j-1].wr - strial;
                n_st[SQ0+j].rt[si] = 1'b1;
            end
        end

        // Smoothing products.
        n_st[SMO].m1 = alpha_s * r_st[SMO-1].gold;
        n_st[SMO].m2 = (lrwg_pkg::ONE_Q16 - alpha_s) * r_st[SMO-1].rt;

        // Smoothed gain; out-of-range bins pass at unity.
        gsum = r_st[GST-1].m1 + r_st[GST-1].m2 + 34'd32768;
        n_st[GST].g = r_st[GST-1].inr ? gsum[32:16] : lrwg_pkg::ONE_Q16;

        // Gain applied to both parts.
        n_st[PRD].pr = r_st[PRD-1].re * $signed({1'b0, r_st[PRD-1].g});
        n_st[PRD].pi = r_st[PRD-1].im * $signed({1'b0, r_st[PRD-1].g});

        // Rounding to the output width.
        n_st[LST].ore = 24'((r_st[LST-1].pr + 42'sd32768) >>> 16);
        n_st[LST].oim = 24'((r_st[LST-1].pi + 42'sd32768) >>> 16);
    end

    // Pipeline registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NST; s++) begin
                r_v[s] <= 1'b0;
            end
        end else if (en) begin
            r_v[0] <= accept;
            for (int s = 1; s < NST; s++) begin
                r_v[s] <= r_v[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_st <= n_st;
        end
    end

    // Frame counter and clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame    <= '0;
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
        end else begin
            if (accept && i_bin.last_bin) begin
                r_frame <= (32'(r_frame) == lrwg_pkg::HIST_FRAMES - 1) ? '0 : r_frame + 1'b1;
            end
            if (r_clr_busy) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (32'(r_clr_cnt) == lrwg_pkg::HIST_DEPTH - 1) begin
                    r_clr_busy <= 1'b0;
                end
            end
        end
    end

    // Write-back of power and smoothed gain, or the clearing pass.
    logic wb_en;
    assign wb_en = en && r_v[GST-1] && r_st[GST-1].inr;

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            hist_mem[r_clr_cnt] <= '0;
            if (32'(r_clr_cnt) < lrwg_pkg::NUM_BINS) begin
                gain_mem[r_clr_cnt[lrwg_pkg::GAIN_AW-1:0]] <= lrwg_pkg::ONE_Q16;
            end
        end else if (wb_en) begin
            hist_mem[r_st[GST-1].addr] <= r_st[GST-1].pw;
            gain_mem[r_st[GST-1].k[lrwg_pkg::GAIN_AW-1:0]] <= n_st[GST].g;
        end
        if (accept && in_range) begin
            r_hist_rd <= hist_mem[in_addr];
            r_gain_rd <= gain_mem[i_bin.bin_index[lrwg_pkg::GAIN_AW-1:0]];
        end
    end

    // Output word.
    assign o_bin.valid        = r_v[LST];
    assign o_bin.out_real     = r_st[LST].ore;
    assign o_bin.out_imag     = r_st[LST].oim;
    assign o_bin.applied_gain = r_st[LST].g;
    assign o_bin.frame_end    = r_st[LST].last;

`ifndef SYNTHESIS
    // No word enters while the memories are being cleared.
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !accept) else $error("word accepted during clearing pass");

    // The frame counter stays inside the history depth.
    a_frame_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_frame) < lrwg_pkg::HIST_FRAMES) else $error("frame counter out of range");

    // The delivered gain never exceeds unity.
    a_gain_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_bin.valid |-> o_bin.applied_gain <= lrwg_pkg::ONE_Q16) else $error("gain above one");

    // Out-of-range bins leave at unity gain.
    a_bypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[LST] && !r_st[LST].inr) |-> r_st[LST].g == lrwg_pkg::ONE_Q16)
        else $error("out-of-range bin not at unity");

    // A stalled output holds the whole pipeline, so the output word stays.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[LST] && !o_bin.ready) |=> (r_v[LST] && $stable(r_st[LST].g)))
        else $error("output word lost under stall");
`endif

endmodule

// ===== test/late_reverb_wiener_bin_gain_tb.sv =====
// Self-checking testbench for the late-reverb Wiener bin gain block.
// Drives bin words and register writes, predicts each gained word and compares them.
// Depends on lrwg_pkg, lrwg_in_if, lrwg_out_if and late_reverb_wiener_bin_gain.
`timescale 1ns / 1ps

module late_reverb_wiener_bin_gain_tb;

    typedef struct packed {
        logic signed [lrwg_pkg::SAMPLE_W-1:0] re;
        logic signed [lrwg_pkg::SAMPLE_W-1:0] im;
        logic [lrwg_pkg::GAIN_W-1:0]          gain;
        logic                                 fend;
    } t_gained_bin;

    typedef struct {
        logic signed [lrwg_pkg::SAMPLE_W-1:0] re;
        logic signed [lrwg_pkg::SAMPLE_W-1:0] im;
        logic [lrwg_pkg::INDEX_W-1:0]         idx;
        logic                                 last;
        logic                                 has_exp;
        t_gained_bin                          exp;
    } t_stim_row;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 80;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [lrwg_pkg::CFG_AW-1:0] i_cfg_index;
    logic [lrwg_pkg::CFG_DW-1:0] i_cfg_wdata;

    lrwg_in_if  bin_in ();
    lrwg_out_if bin_out ();

    late_reverb_wiener_bin_gain dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_wdata(i_cfg_wdata),
        .i_bin      (bin_in.sink),
        .o_bin      (bin_out.source)
    );

    // Predictor state: registers and per-bin memories.
    logic [16:0] m_amount, m_floor, m_vfloor, m_alpha;
    logic [19:0] m_scale;
    logic        m_voice;
    logic [9:0]  m_band_lo, m_band_hi;
    logic [47:0] power_mem [lrwg_pkg::HIST_DEPTH];
    logic [16:0] gain_mem [lrwg_pkg::NUM_BINS];
    int unsigned frame_ptr;

    t_gained_bin expected_words[$];
    int errors;
    int words_seen;
    int cycle_count;
    bit quiet;       // no idling on either side while set

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Timeout guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [16:0] sat_one(logic [16:0] v);
        return (v > 17'd65536) ? 17'd65536 : v;
    endfunction

    function automatic logic [31:0] int_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= r + bitv) begin
                v -= r + bitv;
                r = (r >> 1) + bitv;
            end else begin
                r >>= 1;
            end
            bitv >>= 2;
        end
        return r[31:0];
    endfunction

    // Rounded x*g >> 16 with floor semantics for negative products.
    function automatic logic [23:0] scale_sample(logic signed [23:0] x, logic [16:0] g);
        logic signed [63:0] prod;
        prod = 64'(x) * $signed({47'd0, g});
        return 24'((prod + 64'sd32768) >>> 16);
    endfunction

    // Computes the gained word for one bin and updates the history and gain memories.
    function automatic t_gained_bin predict_gained_bin(logic signed [23:0] re,
                                                       logic signed [23:0] im,
                                                       logic [9:0] idx, logic last);
        t_gained_bin w;
        logic [16:0] g;
        logic [63:0] pw, d, p, m, thr, ratio, fl2, wp, l;
        logic [16:0] fl, a;
        logic [31:0] target;
        int unsigned slot;
        logic in_band;
        g = 17'd65536;
        if (idx < lrwg_pkg::NUM_BINS) begin
            pw = 64'((64'(re) * 64'(re)) + (64'(im) * 64'(im))) & 64'hFFFF_FFFF_FFFF;
            slot = frame_ptr * lrwg_pkg::NUM_BINS + idx;
            d = power_mem[slot];
            l = m_scale;
            ratio = 0;
            if (l != 0 && d != 0) begin
                p = (pw == 0) ? 64'd1 : pw;
                m = p << 16;
                thr = m / l + ((m % l) != 0 ? 64'd1 : 64'd0);
                ratio = (d >= thr) ? 64'd65536 : (l * d) / p;
            end
            in_band = m_voice && idx >= m_band_lo && idx <= m_band_hi;
            fl = sat_one(in_band ? m_vfloor : m_floor);
            fl2 = 64'(fl) * 64'(fl);
            wp = (64'd1 << 32) - 64'(sat_one(m_amount)) * ratio;
            if (wp < fl2) wp = fl2;
            target = int_sqrt(wp);
            a = sat_one(m_alpha);
            g = 17'((64'(a) * 64'(gain_mem[idx]) + 64'(17'd65536 - a) * 64'(target)
                     + 64'd32768) >> 16);
            gain_mem[idx] = g;
            power_mem[slot] = pw[47:0];
        end
        if (last) frame_ptr = (frame_ptr + 1) % lrwg_pkg::HIST_FRAMES;
        w.re = scale_sample(re, g);
        w.im = scale_sample(im, g);
        w.gain = g;
        w.fend = last;
        return w;
    endfunction

    // Output side: random backpressure and word-by-word comparison.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            bin_out.ready <= 1'b0;
        end else begin
            bin_out.ready <= quiet || ($urandom_range(99) >= 17);
            if (bin_out.valid && bin_out.ready) begin
                words_seen <= words_seen + 1;
                if (expected_words.size() == 0) begin
                    $error("unexpected output word");
                    errors++;
                end else begin
                    t_gained_bin e;
                    e = expected_words.pop_front();
                    if (bin_out.out_real !== e.re) begin
                        $error("out_real exp %0d got %0d", e.re, bin_out.out_real);
                        errors++;
                    end
                    if (bin_out.out_imag !== e.im) begin
                        $error("out_imag exp %0d got %0d", e.im, bin_out.out_imag);
                        errors++;
                    end
                    if (bin_out.applied_gain !== e.gain) begin
                        $error("applied_gain exp %0d got %0d", e.gain, bin_out.applied_gain);
                        errors++;
                    end
                    if (bin_out.frame_end !== e.fend) begin
                        $error("frame_end exp %0d got %0d", e.fend, bin_out.frame_end);
                        errors++;
                    end
                end
            end
        end
    end

    // One register write; the enable drops between one write and the next.
    task automatic write_reg(lrwg_pkg::t_reg_idx r, logic [19:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= r;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (r)
            lrwg_pkg::REG_AMOUNT:      m_amount  = v[16:0];
            lrwg_pkg::REG_LATE_SCALE:  m_scale   = v;
            lrwg_pkg::REG_FLOOR_GAIN:  m_floor   = v[16:0];
            lrwg_pkg::REG_VOICE_FLOOR: m_vfloor  = v[16:0];
            lrwg_pkg::REG_SMOOTH:      m_alpha   = v[16:0];
            lrwg_pkg::REG_VOICE_MODE:  m_voice   = v[0];
            lrwg_pkg::REG_SPEECH_LOW:  m_band_lo = v[9:0];
            lrwg_pkg::REG_SPEECH_HIGH: m_band_hi = v[9:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Sends one bin word, with a random gap first, and queues its prediction.
    // Valid only drops in a gap,
    // so back-to-back words keep it high.
    task automatic send_bin(logic signed [23:0] re, logic signed [23:0] im,
                            logic [9:0] idx, logic last);
        t_gained_bin w;
        while (!quiet && $urandom_range(99) < 17) begin
            bin_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        bin_in.valid     <= 1'b1;
        bin_in.bin_real  <= re;
        bin_in.bin_imag  <= im;
        bin_in.bin_index <= idx;
        bin_in.last_bin  <= last;
        w = predict_gained_bin(re, im, idx, last);
        expected_words.push_back(w);
        do @(posedge i_clk); while (!bin_in.ready);
    endtask

    // Waits for every expected word, then lets the pipeline settle.
    task automatic drain();
        bin_in.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [23:0] rand_sample();
        case ($urandom_range(5))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return 24'($urandom_range(255)) - 24'sd128;
            default: return 24'($urandom);
        endcase
    endfunction

    // Sends a burst of frames over the first nbins bins.
    task automatic send_frames(int frames, int nbins, int loud_pct);
        for (int f = 0; f < frames; f++) begin
            for (int k = 0; k < nbins; k++) begin
                logic signed [23:0] re, im;
                if ($urandom_range(99) < loud_pct) begin
                    re = rand_sample();
                    im = rand_sample();
                end else begin
                    re = 24'($urandom_range(31)) - 24'sd16;
                    im = ($urandom_range(3) == 0) ? 24'sd0 : 24'($urandom_range(7));
                end
                send_bin(re, im, 10'(k), k == nbins - 1);
            end
        end
    endtask

    t_stim_row dir_rows[$];
    int sent;

    function automatic t_stim_row row(int re, int im, int idx, logic last,
                                      logic has, int gre, int gim, int gg);
        t_stim_row r;
        r.re = 24'(re); r.im = 24'(im); r.idx = 10'(idx); r.last = last;
        r.has_exp = has;
        r.exp.re = 24'(gre); r.exp.im = 24'(gim); r.exp.gain = 17'(gg); r.exp.fend = last;
        return r;
    endfunction

    initial begin
        t_gained_bin pred;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        bin_in.valid = 1'b0;
        bin_in.bin_real = '0;
        bin_in.bin_imag = '0;
        bin_in.bin_index = '0;
        bin_in.last_bin = 1'b0;
        bin_out.ready = 1'b0;
        errors = 0; words_seen = 0; cycle_count = 0; sent = 0; quiet = 1'b0;
        m_amount = 17'd65536; m_scale = 20'd16384; m_floor = 17'd6554;
        m_vfloor = 17'd23170; m_alpha = 17'd45875; m_voice = 1'b0;
        m_band_lo = 10'd4; m_band_hi = 10'd85;
        foreach (power_mem[i]) power_mem[i] = '0;
        foreach (gain_mem[i]) gain_mem[i] = 17'd65536;
        frame_ptr = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows: fresh history gives unity gain, so words pass unchanged.
        dir_rows.push_back(row(8388607, -8388608, 0, 0, 1, 8388607, -8388608, 65536));
        dir_rows.push_back(row(0, 0, 1, 0, 1, 0, 0, 65536));
        dir_rows.push_back(row(-1, 1, 512, 0, 1, -1, 1, 65536));
        dir_rows.push_back(row(100, -100, 1000, 0, 1, 100, -100, 65536));
        dir_rows.push_back(row(1023, 5, 1023, 1, 1, 1023, 5, 65536));
        // Frame wrap: revisit bins 0, 1, 2 and 512 after the history has cycled.
        for (int f = 0; f < lrwg_pkg::HIST_FRAMES - 1; f++)
            dir_rows.push_back(row(7, 3, 2, 1, 0, 0, 0, 0));
        dir_rows.push_back(row(0, 0, 0, 0, 0, 0, 0, 0));          // zero power, history full
        dir_rows.push_back(row(1000, 1000, 1, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(-8388608, -8388608, 512, 1, 0, 0, 0, 0));
        dir_rows.push_back(row(7, 3, 2, 1, 0, 0, 0, 0));

        foreach (dir_rows[i]) begin
            t_stim_row r;
            r = dir_rows[i];
            send_bin(r.re, r.im, r.idx, r.last);
            sent++;
            if (r.has_exp) begin
                pred = expected_words[$];
                if (pred !== r.exp) begin
                    $error("directed row %0d: typed expectation differs from prediction", i);
                    errors++;
                end
            end
        end
        drain();

        // Register extremes, including values above one and the speech band.
        write_reg(lrwg_pkg::REG_AMOUNT, 20'd131071);
        write_reg(lrwg_pkg::REG_LATE_SCALE, 20'hFFFFF);
        write_reg(lrwg_pkg::REG_FLOOR_GAIN, 20'd0);
        write_reg(lrwg_pkg::REG_VOICE_FLOOR, 20'd131071);
        write_reg(lrwg_pkg::REG_SMOOTH, 20'd0);
        write_reg(lrwg_pkg::REG_VOICE_MODE, 20'd1);
        write_reg(lrwg_pkg::REG_SPEECH_LOW, 20'd0);
        write_reg(lrwg_pkg::REG_SPEECH_HIGH, 20'd3);
        send_frames(12, 8, 50);
        sent += 96;
        drain();

        // Randomized settings over nine phases, with phase 4 run quiet.
        for (int ph = 0; ph < 9; ph++) begin
            quiet = (ph == 4);
            write_reg(lrwg_pkg::REG_AMOUNT,
                      (ph % 3 == 0) ? 20'd0 : 20'($urandom_range(70000)));
            write_reg(lrwg_pkg::REG_LATE_SCALE, (ph == 2) ? 20'd0 :
                      (ph == 5) ? 20'hFFFFF : 20'($urandom_range(1048575)));
            write_reg(lrwg_pkg::REG_FLOOR_GAIN,
                      (ph == 6) ? 20'd65536 : 20'($urandom_range(66000)));
            write_reg(lrwg_pkg::REG_VOICE_FLOOR, 20'($urandom_range(131071)));
            write_reg(lrwg_pkg::REG_SMOOTH, (ph == 7) ? 20'd65536 :
                      (ph == 8) ? 20'hFFFFF : 20'($urandom_range(65536)));
            write_reg(lrwg_pkg::REG_VOICE_MODE, 20'(ph & 1));
            write_reg(lrwg_pkg::REG_SPEECH_LOW, 20'($urandom_range(1023)));
            write_reg(lrwg_pkg::REG_SPEECH_HIGH,
                      (ph == 3) ? 20'd1023 : 20'($urandom_range(30)));
            if (ph == 7) begin
                // One full-size frame, plus twenty out-of-range bins.
                send_frames(1, lrwg_pkg::NUM_BINS, 40);
                sent += lrwg_pkg::NUM_BINS;
                for (int j = 0; j < 20; j++) begin
                    send_bin(rand_sample(), rand_sample(),
                             10'($urandom_range(1023, lrwg_pkg::NUM_BINS)),
                             1'($urandom_range(1)));
                    sent++;
                end
            end else begin
                send_frames(10, 12, 60);
                sent += 120;
            end
            drain();
        end
        quiet = 1'b0;

        $display("Sent %0d bin words across eleven register settings; %0d words checked.",
                 sent, words_seen);
        if (errors == 0 && expected_words.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
